// ===== src/qwee_pkg.sv =====
// Shared types, constants and the sequencer program of the Walsh energy evaluator.
package qwee_pkg;

    localparam int ENERGY_W   = 48;
    localparam int VIN_W      = 7;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int COEF_IN_W  = 32;
    localparam int BITS_W     = 64;
    localparam int OP_W       = 2;
    localparam int IN_TDATA_W = 112;

    localparam int ROW_LSB  = 0;
    localparam int COL_LSB  = ROW_LSB + ROW_W;
    localparam int COEF_LSB = COL_LSB + COL_W;
    localparam int BITS_LSB = COEF_LSB + COEF_IN_W;

    localparam logic [VIN_W-1:0] VIN_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_LIN  = 2'd0,
        OP_LOAD_PAIR = 2'd1,
        OP_EVAL      = 2'd2
    } op_t;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t S_IDLE  = 3'd0;
    localparam step_t S_INIT  = 3'd1;
    localparam step_t S_LIN   = 3'd2;
    localparam step_t S_PSET  = 3'd3;
    localparam step_t S_PAIR  = 3'd4;
    localparam step_t S_DRAIN = 3'd5;
    localparam step_t S_DONE  = 3'd6;

    typedef enum logic [2:0] {
        C_NEXT      = 3'd0,
        C_ALWAYS    = 3'd1,
        C_NO_EVAL   = 3'd2,
        C_N_ZERO    = 3'd3,
        C_LIN_MORE  = 3'd4,
        C_N_ONE     = 3'd5,
        C_PAIR_MORE = 3'd6,
        C_OUT_BUSY  = 3'd7
    } cond_t;

    typedef struct packed {
        logic  take_in;
        logic  clr;
        logic  lin_rd;
        logic  pset;
        logic  pair_rd;
        logic  emit;
        cond_t cond;
        step_t tgt;
    } cw_t;

    // Jump to tgt when cond holds, else advance one step.
    function automatic cw_t ucode(input step_t step);
        cw_t cw;
        cw = '{take_in: 1'b0, clr: 1'b0, lin_rd: 1'b0, pset: 1'b0, pair_rd: 1'b0,
               emit: 1'b0, cond: C_ALWAYS, tgt: S_IDLE};
        case (step)
            S_IDLE:
            begin
                cw.take_in = 1'b1;
                cw.cond    = C_NO_EVAL;
                cw.tgt     = S_IDLE;
            end
            S_INIT:
            begin
                cw.clr  = 1'b1;
                cw.cond = C_N_ZERO;
                cw.tgt  = S_DRAIN;
            end
            S_LIN:
            begin
                cw.lin_rd = 1'b1;
                cw.cond   = C_LIN_MORE;
                cw.tgt    = S_LIN;
            end
            S_PSET:
            begin
                cw.pset = 1'b1;
                cw.cond = C_N_ONE;
                cw.tgt  = S_DRAIN;
            end
            S_PAIR:
            begin
                cw.pair_rd = 1'b1;
                cw.cond    = C_PAIR_MORE;
                cw.tgt     = S_PAIR;
            end
            S_DRAIN:
            begin
                cw.cond = C_OUT_BUSY;
                cw.tgt  = S_DRAIN;
            end
            S_DONE:
            begin
                cw.emit = 1'b1;
                cw.cond = C_ALWAYS;
                cw.tgt  = S_IDLE;
            end
            default:
            begin
                cw.cond = C_ALWAYS;
                cw.tgt  = S_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== src/qwee_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module qwee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/quadratic_walsh_energy_eval_core.sv =====
// Top level: coefficient tables, microcoded sequencer and signed accumulator.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: row, col, coefficient, bits; tuser: op
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: energy
//  cfg       in   cfg_valid/cfg_ready           cfg_data: vars_in_use
//
//  A load leaves the block idle, so it stays ready for the next item.
//  An evaluate reads one entry per cycle through the single read port of the linear,
//  then the pair coefficient RAM, and shows its result once the output is free.
//  Reset clears the sequencer, the output valid and vars_in_use (to 64);
//  the tables are not cleared. A stalled result holds in the output register
//  and the next item is accepted meanwhile; only a new result waits for it.
module quadratic_walsh_energy_eval_core #(
    parameter int MAX_VARS   = 64,
    parameter int COEF_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [5:0] row_index, [11:6] col_index, [43:12] coefficient, [107:44] bits, [111:108] zero
    input  logic [qwee_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // [1:0] op
    input  logic [qwee_pkg::OP_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [47:0] energy
    output logic [qwee_pkg::ENERGY_W-1:0]   m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [qwee_pkg::VIN_W-1:0]      cfg_data
);

    localparam int IDX_W      = $clog2(MAX_VARS);
    localparam int PAIR_DEPTH = (MAX_VARS * (MAX_VARS - 1)) / 2;
    localparam int PAIR_AW    = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int EW         = qwee_pkg::ENERGY_W;
    localparam int VW         = qwee_pkg::VIN_W;
    localparam logic [VW-1:0] VAR_LIM = VW'(MAX_VARS);

    // Input fields
    logic [qwee_pkg::ROW_W-1:0]     in_row;
    logic [qwee_pkg::COL_W-1:0]     in_col;
    logic [qwee_pkg::COEF_IN_W-1:0] in_coef;
    logic [qwee_pkg::BITS_W-1:0]    in_bits;
    logic                           in_acc;
    logic                           is_eval;

    assign in_row  = s_axis_tdata[qwee_pkg::ROW_LSB +: qwee_pkg::ROW_W];
    assign in_col  = s_axis_tdata[qwee_pkg::COL_LSB +: qwee_pkg::COL_W];
    assign in_coef = s_axis_tdata[qwee_pkg::COEF_LSB +: qwee_pkg::COEF_IN_W];
    assign in_bits = s_axis_tdata[qwee_pkg::BITS_LSB +: qwee_pkg::BITS_W];

    // Sequencer
    qwee_pkg::step_t step_reg, step_next;
    qwee_pkg::cw_t   cw;
    logic            jump;

    assign cw            = qwee_pkg::ucode(step_reg);
    assign s_axis_tready = cw.take_in;
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign is_eval       = (s_axis_tuser == qwee_pkg::OP_EVAL);

    // Config register
    logic [VW-1:0] vin_reg;
    logic [VW-1:0] n_eff;

    assign cfg_ready = 1'b1;
    assign n_eff     = (vin_reg > VAR_LIM) ? VAR_LIM : vin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vin_reg <= qwee_pkg::VIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            vin_reg <= cfg_data;
        end
    end

    // Table writes
    logic                   row_ok;
    logic                   lin_we;
    logic                   pair_we;
    logic [11:0]            tri_base;
    logic [PAIR_AW-1:0]     pair_waddr;
    logic [COEF_WIDTH-1:0]  coef_fit;

    assign row_ok   = ({1'b0, in_row} < VAR_LIM);
    assign lin_we   = in_acc && (s_axis_tuser == qwee_pkg::OP_LOAD_LIN) && row_ok;
    assign pair_we  = in_acc && (s_axis_tuser == qwee_pkg::OP_LOAD_PAIR) && row_ok
                      && (in_col < in_row);
    assign tri_base = (12'(in_row) * (12'(in_row) - 12'd1)) >> 1;
    assign pair_waddr = PAIR_AW'(tri_base + 12'(in_col));
    assign coef_fit = COEF_WIDTH'($signed(in_coef));

    // Walk counters
    logic [IDX_W-1:0]    r_reg, r_next;
    logic [IDX_W-1:0]    c_reg, c_next;
    logic [PAIR_AW-1:0]  paddr_reg, paddr_next;
    logic [MAX_VARS-1:0] bits_reg;
    logic                lin_last;
    logic                row_end;
    logic                pair_last;

    assign lin_last  = (VW'(r_reg) + VW'(1) == n_eff);
    assign row_end   = (VW'(c_reg) + VW'(1) == VW'(r_reg));
    assign pair_last = lin_last && row_end;

    logic [COEF_WIDTH-1:0] lin_rdata;
    logic [COEF_WIDTH-1:0] pair_rdata;

    qwee_ram #(
        .WIDTH (COEF_WIDTH),
        .DEPTH (MAX_VARS)
    ) u_lin_ram (
        .clk   (clk),
        .we    (lin_we),
        .waddr (in_row[IDX_W-1:0]),
        .wdata (coef_fit),
        .raddr (r_reg),
        .rdata (lin_rdata)
    );

    qwee_ram #(
        .WIDTH (COEF_WIDTH),
        .DEPTH (PAIR_DEPTH)
    ) u_pair_ram (
        .clk   (clk),
        .we    (pair_we),
        .waddr (pair_waddr),
        .wdata (coef_fit),
        .raddr (paddr_reg),
        .rdata (pair_rdata)
    );

    always_comb
    begin
        case (cw.cond)
            qwee_pkg::C_NEXT:      jump = 1'b0;
            qwee_pkg::C_ALWAYS:    jump = 1'b1;
            qwee_pkg::C_NO_EVAL:   jump = !(in_acc && is_eval);
            qwee_pkg::C_N_ZERO:    jump = (n_eff == '0);
            qwee_pkg::C_LIN_MORE:  jump = !lin_last;
            qwee_pkg::C_N_ONE:     jump = (n_eff == VW'(1));
            qwee_pkg::C_PAIR_MORE: jump = !pair_last;
            qwee_pkg::C_OUT_BUSY:  jump = m_axis_tvalid && !m_axis_tready;
            default:               jump = 1'b1;
        endcase
        step_next = jump ? cw.tgt : step_reg + qwee_pkg::step_t'(1);
    end

    always_comb
    begin
        r_next     = r_reg;
        c_next     = c_reg;
        paddr_next = paddr_reg;
        if (cw.clr)
        begin
            r_next = '0;
        end
        if (cw.lin_rd)
        begin
            r_next = r_reg + IDX_W'(1);
        end
        if (cw.pset)
        begin
            r_next     = IDX_W'(1);
            c_next     = '0;
            paddr_next = '0;
        end
        if (cw.pair_rd)
        begin
            paddr_next = paddr_reg + PAIR_AW'(1);
            if (row_end)
            begin
                c_next = '0;
                r_next = r_reg + IDX_W'(1);
            end
            else
            begin
                c_next = c_reg + IDX_W'(1);
            end
        end
    end

    // Accumulate one term per cycle, in the cycle after its table read
    logic                  term_v_reg;
    logic                  term_sub_reg;
    logic                  term_pair_reg;
    logic [EW-1:0]         acc_reg, acc_next;
    logic [EW-1:0]         term;
    logic [EW-1:0]         out_data_reg;
    logic                  out_valid_reg;

    assign term = term_pair_reg ? EW'($signed(pair_rdata)) : EW'($signed(lin_rdata));

    always_comb
    begin
        acc_next = acc_reg;
        if (cw.clr)
        begin
            acc_next = '0;
        end
        else if (term_v_reg)
        begin
            acc_next = term_sub_reg ? acc_reg - term : acc_reg + term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= qwee_pkg::S_IDLE;
            term_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            term_v_reg <= cw.lin_rd | cw.pair_rd;
            if (cw.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg         <= r_next;
        c_reg         <= c_next;
        paddr_reg     <= paddr_next;
        acc_reg       <= acc_next;
        term_pair_reg <= cw.pair_rd;
        term_sub_reg  <= cw.pair_rd ? (bits_reg[r_reg] ^ bits_reg[c_reg]) : bits_reg[r_reg];
        if (in_acc && is_eval)
        begin
            bits_reg <= in_bits[MAX_VARS-1:0];
        end
        if (cw.emit)
        begin
            out_data_reg <= acc_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== src/qwee_chk.sv =====
// Port-level checker for the Walsh energy evaluator, bound to the top level.
module qwee_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [qwee_pkg::OP_W-1:0]       s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [qwee_pkg::ENERGY_W-1:0]   m_axis_tdata
);

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // An evaluate takes the block busy on the next cycle
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (s_axis_tuser == qwee_pkg::OP_EVAL) |=> !s_axis_tready)
        else $error("ready after evaluate");

    // Loads and unused ops leave the block ready on the next cycle
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (s_axis_tuser != qwee_pkg::OP_EVAL) |=> s_axis_tready)
        else $error("not ready after load");

    // A new result appears only at the end of an evaluation
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without evaluation");

endmodule

bind quadratic_walsh_energy_eval_core qwee_chk u_qwee_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/tb_quadratic_walsh_energy_eval_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the quadratic Walsh energy evaluator core.
module tb_quadratic_walsh_energy_eval_core;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int TAIL_CYCLES   = 2200;
    localparam int LONG_HOLD     = 4000;
    localparam int N_VARS        = 64;
    localparam int FILL_VARS     = 16;
    localparam int PHASE_ITEMS   = 9;
    localparam int SQUEEZE_ITEMS = 20;

    localparam logic [qwee_pkg::OP_W-1:0]      OP_UNUSED = 2'd3;
    localparam logic [qwee_pkg::COEF_IN_W-1:0] COEF_MAX  = 32'h7FFF_FFFF;
    localparam logic [qwee_pkg::COEF_IN_W-1:0] COEF_MIN  = 32'h8000_0000;
    localparam logic [qwee_pkg::BITS_W-1:0]    ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [qwee_pkg::OP_W-1:0]      op;
        logic [qwee_pkg::ROW_W-1:0]     row;
        logic [qwee_pkg::COL_W-1:0]     col;
        logic [qwee_pkg::COEF_IN_W-1:0] coef;
        logic [qwee_pkg::BITS_W-1:0]    bits;
    } walsh_item_t;

    typedef struct packed {
        logic                          cfg;
        logic [qwee_pkg::VIN_W-1:0]    vin;
        walsh_item_t                   item;
        logic                          typed;
        logic [qwee_pkg::ENERGY_W-1:0] energy;
    } plan_row_t;

    localparam int DIR_ROWS = 21;
    localparam plan_row_t DIRECTED [DIR_ROWS] = '{
        '{1'b1, 7'd0, '{qwee_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0, 64'd0}, 1'b0, 48'd0},
        // nothing in use sums to zero
        '{1'b0, 7'd0, '{qwee_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0, ALL_ONES}, 1'b1, 48'd0},
        '{1'b1, 7'd1, '{qwee_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0, 64'd0}, 1'b0, 48'd0},
        '{1'b0, 7'd0, '{qwee_pkg::OP_LOAD_LIN, 6'd0, 6'd0, COEF_MAX, 64'd0}, 1'b0, 48'd0},
        '{1'b0, 7'd0, '{qwee_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0, 64'd0}, 1'b1, 48'h0000_7FFF_FFFF},
        '{1'b0, 7'd0, '{qwee_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0, 64'd1}, 1'b1, 48'hFFFF_8000_0001},
        '{1'b0, 7'd0, '{qwee_pkg::OP_LOAD_LIN, 6'd0, 6'd0, COEF_MIN, 64'd0}, 1'b0, 48'd0},
        '{1'b0, 7'd0, '{qwee_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0, 64'd0}, 1'b1, 48'hFFFF_8000_0000},
        '{1'b0, 7'd0, '{qwee_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0, ALL_ONES}, 1'b1, 48'h0000_8000_0000},
        '{1'b1, 7'd2, '{qwee_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0, 64'd0}, 1'b0, 48'd0},
        '{1'b0, 7'd0, '{qwee_pkg::OP_LOAD_LIN, 6'd1, 6'd0, 32'hFFFF_FFFF, 64'd0}, 1'b0, 48'd0},
        '{1'b0, 7'd0, '{qwee_pkg::OP_LOAD_PAIR, 6'd1, 6'd0, COEF_MAX, 64'd0}, 1'b0, 48'd0},
        // column not below row: dropped
        '{1'b0, 7'd0, '{qwee_pkg::OP_LOAD_PAIR, 6'd1, 6'd1, 32'h1234_5678, 64'd0}, 1'b0, 48'd0},
        '{1'b0, 7'd0, '{qwee_pkg::OP_LOAD_PAIR, 6'd63, 6'd63, 32'h5A5A_5A5A, 64'd0}, 1'b0, 48'd0},
        '{1'b0, 7'd0, '{qwee_pkg::OP_LOAD_PAIR, 6'd0, 6'd63, COEF_MIN, 64'd0}, 1'b0, 48'd0},
        // unused op aimed at a live pair entry must not touch it
        '{1'b0, 7'd0, '{OP_UNUSED, 6'd1, 6'd0, 32'd0, 64'd0}, 1'b0, 48'd0},
        '{1'b0, 7'd0, '{qwee_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0, 64'd0}, 1'b0, 48'd0},
        '{1'b0, 7'd0, '{qwee_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0, 64'd2}, 1'b0, 48'd0},
        '{1'b0, 7'd0, '{qwee_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0, ALL_ONES}, 1'b0, 48'd0},
        '{1'b0, 7'd0, '{qwee_pkg::OP_LOAD_LIN, 6'd63, 6'd0, COEF_MIN, 64'd0}, 1'b0, 48'd0},
        '{1'b0, 7'd0, '{qwee_pkg::OP_EVAL, 6'd0, 6'd0, 32'd0, 64'd1}, 1'b0, 48'd0}
    };

    localparam int SMALL_PHASES = 12;
    localparam logic [qwee_pkg::VIN_W-1:0] SMALL_VIN [SMALL_PHASES] = '{
        7'd1, 7'd0, 7'd2, 7'd4, 7'd7, 7'd12, 7'd3, 7'd9, 7'd5, 7'd16, 7'd6, 7'd2
    };
    localparam int SQUEEZE_PHASE = 3;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [qwee_pkg::IN_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [qwee_pkg::OP_W-1:0]       s_axis_tuser  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [qwee_pkg::ENERGY_W-1:0]   m_axis_tdata;
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [qwee_pkg::VIN_W-1:0]      cfg_data      = '0;

    // predictor state
    logic signed [qwee_pkg::COEF_IN_W-1:0] lin_coef  [N_VARS];
    logic signed [qwee_pkg::COEF_IN_W-1:0] pair_coef [N_VARS][N_VARS];
    logic [qwee_pkg::VIN_W-1:0]            vars_active = qwee_pkg::VIN_RESET;
    logic [qwee_pkg::ENERGY_W-1:0]         energy_q [$];

    int errors      = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int hold_reqs   = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int rx_mode     = 0;
    int mode_left   = 0;

    quadratic_walsh_energy_eval_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [qwee_pkg::ENERGY_W-1:0] walsh_energy(
        logic [qwee_pkg::BITS_W-1:0] s);
        logic signed [qwee_pkg::ENERGY_W-1:0] acc;
        int n;
        n   = (vars_active > N_VARS) ? N_VARS : int'(vars_active);
        acc = '0;
        for (int r = 0; r < n; r++)
        begin
            if (s[r])
                acc = acc - lin_coef[r];
            else
                acc = acc + lin_coef[r];
            for (int c = 0; c < r; c++)
            begin
                if (s[r] == s[c])
                    acc = acc + pair_coef[r][c];
                else
                    acc = acc - pair_coef[r][c];
            end
        end
        return acc;
    endfunction

    function automatic void store_coef(walsh_item_t it);
        if (it.op == qwee_pkg::OP_LOAD_LIN)
            lin_coef[it.row] = it.coef;
        else if (it.op == qwee_pkg::OP_LOAD_PAIR && it.col < it.row)
            pair_coef[it.row][it.col] = it.coef;
    endfunction

    function automatic logic [qwee_pkg::COEF_IN_W-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [qwee_pkg::BITS_W-1:0] rand_bits();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALL_ONES;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic walsh_item_t random_item(int n, bit eval_heavy);
        walsh_item_t it;
        int pick;
        int lin_cut;
        int pair_cut;
        int span;
        lin_cut  = eval_heavy ? 8 : 30;
        pair_cut = eval_heavy ? 16 : 55;
        pick     = $urandom_range(0, 99);
        if (pick < lin_cut)
            it.op = qwee_pkg::OP_LOAD_LIN;
        else if (pick < pair_cut)
            it.op = qwee_pkg::OP_LOAD_PAIR;
        else if (pick < 94)
            it.op = qwee_pkg::OP_EVAL;
        else
            it.op = OP_UNUSED;
        // keep half of the loads inside the active range so they matter
        span   = (n >= 2) ? n : N_VARS;
        it.row = $urandom_range(0, 1) ? 6'($urandom_range(0, span - 1))
                                      : 6'($urandom_range(0, 63));
        it.col = 6'($urandom_range(0, 63));
        if (it.op == qwee_pkg::OP_LOAD_PAIR && it.row > 0 && $urandom_range(0, 9) != 0)
            it.col = 6'($urandom_range(0, it.row - 1));
        it.coef = rand_coef();
        it.bits = rand_bits();
        return it;
    endfunction

    task automatic send_item(input walsh_item_t it, input bit typed,
                             input logic [qwee_pkg::ENERGY_W-1:0] typed_energy);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, it.bits, it.coef, it.col, it.row};
        s_axis_tuser  <= it.op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (it.op == qwee_pkg::OP_EVAL)
            energy_q.push_back(typed ? typed_energy : walsh_energy(it.bits));
        else
            store_coef(it);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap        = $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drop valid and wait until every pending energy has been taken
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (energy_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_vars(input logic [qwee_pkg::VIN_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        vars_active = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [qwee_pkg::VIN_W-1:0] v, input int count,
                             input bit squeeze);
        int n;
        settle();
        write_vars(v);
        n = (v > N_VARS) ? N_VARS : int'(v);
        if (squeeze)
            hold_reqs <= hold_reqs + 1;
        repeat (count) send_item(random_item(n, squeeze), 1'b0, '0);
    endtask

    // energy checker and output stall pattern
    always @(posedge clk)
    begin
        logic [qwee_pkg::ENERGY_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (energy_q.size() == 0)
            begin
                $display("%0t: unexpected energy transaction, expected none, actual %h",
                         $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = energy_q.pop_front();
                if (m_axis_tdata !== want)
                begin
                    $display("%0t: energy mismatch, expected %h, actual %h",
                             $time, want, m_axis_tdata);
                    errors++;
                end
            end
        end
        if (hold_reqs != hold_seen)
        begin
            hold_seen = hold_reqs;
            hold_left = LONG_HOLD;
        end
        if (mode_left == 0)
        begin
            rx_mode   = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
        end
        else
            mode_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIRECTED[i].cfg)
            begin
                settle();
                write_vars(DIRECTED[i].vin);
            end
            else
                send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].energy);
        end

        // fill the low rows of both tables so that sizes up to FILL_VARS may be evaluated
        for (int r = 0; r < FILL_VARS; r++)
        begin
            send_item(walsh_item_t'{qwee_pkg::OP_LOAD_LIN, 6'(r), 6'd0, rand_coef(), 64'd0},
                      1'b0, '0);
            for (int c = 0; c < r; c++)
                send_item(walsh_item_t'{qwee_pkg::OP_LOAD_PAIR, 6'(r), 6'(c), rand_coef(),
                                        64'd0}, 1'b0, '0);
        end

        for (int p = 0; p < SMALL_PHASES; p++)
            run_phase(SMALL_VIN[p], (p == SQUEEZE_PHASE) ? SQUEEZE_ITEMS : PHASE_ITEMS,
                      p == SQUEEZE_PHASE);
        run_phase(7'(FILL_VARS), 8, 1'b0);

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
src/qwee_pkg.sv
src/qwee_ram.sv
src/quadratic_walsh_energy_eval_core.sv
src/qwee_chk.sv
sim/tb_quadratic_walsh_energy_eval_core.sv
